// ----- sv/tgi_pkg.sv -----
// Shared request codes, register indexes and fixed-point constants of the grid interpolator.
`default_nettype none
package tgi_pkg;

    // Request kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_TRILIN  = 2'd1,
        REQ_NEAREST = 2'd2
    } req_type_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z   = 3'd2;
    localparam logic [2:0] CFG_INV_STEP_X = 3'd3;
    localparam logic [2:0] CFG_INV_STEP_Y = 3'd4;
    localparam logic [2:0] CFG_INV_STEP_Z = 3'd5;

    // Result kinds carried in the output tuser field.
    localparam logic KIND_TRILIN  = 1'b0;
    localparam logic KIND_NEAREST = 1'b1;

    // One in Q16.16, the reset value of each reciprocal step.
    localparam logic [31:0] ONE_Q16 = 32'd65536;

endpackage
`default_nettype wire

// ----- sv/trilinear_grid_interpolator_top.sv -----
// Top level of the trilinear grid interpolator: coordinate pipeline, banked grid and blend.
`default_nettype none
// The block takes one beat per cycle unless the result side stalls. A query result passes
// through the stage registers in order into the output register, stage 8, and stays there
// while the result side stalls; sample writes give no result. The rate is set by the grid
// memory: it is split into eight banks by the parity of the x, y and z index, so the eight
// corners of a cell are read together, one per bank. Each bank holds ceil(DIM_X/2) *
// ceil(DIM_Y/2) * ceil(DIM_Z/2) samples, rounded up to a power of two per axis.
// A sample must be written before any query touches it; there is no clearing pass after reset.
// Configuration registers may only be written while no beat is in flight.
module trilinear_grid_interpolator_top
    import tgi_pkg::*;
#(
    parameter int DIM_X        = 32,
    parameter int DIM_Y        = 32,
    parameter int DIM_Z        = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cell_x[4:0], cell_y[9:5], cell_z[14:10], sample_value[30:15], point_x[62:31],
    // point_y[94:63], point_z[126:95], zero pad [127]
    input  wire logic [127:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_value[15:0], out_of_range[16], zero pad [23:17]
    output logic [23:0]       m_tdata,
    // result_kind[0]
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_wen,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int XW   = $clog2(DIM_X);
    localparam int YW   = $clog2(DIM_Y);
    localparam int ZW   = $clog2(DIM_Z);
    localparam int MXW  = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);
    localparam int MCW  = MXW + 1;
    localparam int GW   = MXW + 16;
    localparam int HXW  = (DIM_X > 2) ? $clog2((DIM_X + 1) / 2) : 1;
    localparam int HYW  = (DIM_Y > 2) ? $clog2((DIM_Y + 1) / 2) : 1;
    localparam int HZW  = (DIM_Z > 2) ? $clog2((DIM_Z + 1) / 2) : 1;
    localparam int BAW  = HXW + HYW + HZW;
    localparam int BANK_DEPTH = 1 << BAW;
    localparam int RW   = SW + 18;
    localparam int YSW  = RW + 18;
    localparam int PW   = SW + 19;
    localparam int ZSW  = PW + 18;

    // Sample write carried down to the memory stage.
    typedef struct packed {
        logic           ok;
        logic [MCW-1:0] x;
        logic [MCW-1:0] y;
        logic [MCW-1:0] z;
        logic [SW-1:0]  d;
    } wr_t;

    // Per-beat control carried along the pipeline.
    typedef struct packed {
        logic wr;
        logic nearest;
        logic oor;
    } ctl_t;

    // Configuration registers.
    logic [31:0] origin_reg [3];
    logic [31:0] inv_reg    [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                origin_reg[a] <= '0;
                inv_reg[a]    <= ONE_Q16;
            end
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_ORIGIN_X:   origin_reg[0] <= cfg_wdata;
                CFG_ORIGIN_Y:   origin_reg[1] <= cfg_wdata;
                CFG_ORIGIN_Z:   origin_reg[2] <= cfg_wdata;
                CFG_INV_STEP_X: inv_reg[0]    <= cfg_wdata;
                CFG_INV_STEP_Y: inv_reg[1]    <= cfg_wdata;
                CFG_INV_STEP_Z: inv_reg[2]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage valid bits and advance enables; stage 8 is the output register.
    logic [8:1] vld_reg;
    logic [8:1] vld_next;
    logic [8:1] adv;

    ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg, ctl7_reg;
    wr_t  wr1_reg, wr2_reg, wr3_reg, wr4_reg;

    always_comb begin
        adv[8] = !vld_reg[8] || m_tready;
        for (int k = 7; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[1];

    // Request decode at the input.
    logic in_take;
    ctl_t ctl1_next;
    wr_t  wr1_next;

    always_comb begin
        in_take   = 1'b0;
        ctl1_next = '0;
        unique case (s_tuser)
            REQ_WRITE: begin
                in_take      = 1'b1;
                ctl1_next.wr = 1'b1;
            end
            REQ_TRILIN: begin
                in_take = 1'b1;
            end
            REQ_NEAREST: begin
                in_take           = 1'b1;
                ctl1_next.nearest = 1'b1;
            end
            default: ;
        endcase
        wr1_next.ok = ({4'b0, s_tdata[4:0]} < 9'(DIM_X)) &&
                      ({4'b0, s_tdata[9:5]} < 9'(DIM_Y)) &&
                      ({4'b0, s_tdata[14:10]} < 9'(DIM_Z));
        wr1_next.x  = MCW'(s_tdata[4:0]);
        wr1_next.y  = MCW'(s_tdata[9:5]);
        wr1_next.z  = MCW'(s_tdata[14:10]);
        wr1_next.d  = SW'($signed(s_tdata[30:15]));
    end

    always_comb begin
        vld_next[1] = s_tvalid && in_take;
        vld_next[2] = vld_reg[1];
        vld_next[3] = vld_reg[2];
        vld_next[4] = vld_reg[3];
        vld_next[5] = vld_reg[4] && !ctl4_reg.wr;
        vld_next[6] = vld_reg[5];
        vld_next[7] = vld_reg[6];
        vld_next[8] = vld_reg[7];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 1; k <= 8; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // Control and write payload down to the memory stage.
    logic [2:0] oor_ax;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            ctl1_reg <= ctl1_next;
            wr1_reg  <= wr1_next;
        end
        if (adv[2]) begin
            ctl2_reg <= ctl1_reg;
            wr2_reg  <= wr1_reg;
        end
        if (adv[3]) begin
            ctl3_reg <= '{wr: ctl2_reg.wr, nearest: ctl2_reg.nearest, oor: |oor_ax};
            wr3_reg  <= wr2_reg;
        end
        if (adv[4]) begin
            ctl4_reg <= ctl3_reg;
            wr4_reg  <= wr3_reg;
        end
        if (adv[5]) ctl5_reg <= ctl4_reg;
        if (adv[6]) ctl6_reg <= ctl5_reg;
        if (adv[7]) ctl7_reg <= ctl6_reg;
    end

    // Per-axis coordinate pipeline: offset, scale, clamp, split into cell and fraction.
    logic [MCW-1:0] b4_reg [3];
    logic [16:0]    f4_reg [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam int DA = (a == 0) ? DIM_X : ((a == 1) ? DIM_Y : DIM_Z);
        localparam logic [48:0] LIM = 49'(DA - 1) << 16;

        logic signed [32:0] diff1_reg;
        logic signed [32:0] diff_next;
        logic [31:0]        pt;
        logic [32:0]        mag;
        logic [64:0]        prod2_reg;
        logic               neg2_reg;
        logic [GW-1:0]      g3_reg;
        logic [GW-1:0]      g_next;
        logic               oor_next;
        logic [MXW-1:0]     c;
        logic [GW:0]        nsum;
        logic [MCW-1:0]     b_next;
        logic [16:0]        f_next;

        assign pt = s_tdata[31 + 32*a +: 32];
        assign diff_next = $signed({pt[31], pt}) - $signed({origin_reg[a][31], origin_reg[a]});

        // Offset from the origin, then the magnitude times the reciprocal step.
        assign mag = diff1_reg[32] ? 33'(-diff1_reg) : 33'(diff1_reg);

        // Clamp the Q16.16 coordinate to the grid.
        always_comb begin
            g_next   = prod2_reg[GW+15:16];
            oor_next = 1'b0;
            if (neg2_reg) begin
                g_next   = '0;
                oor_next = |prod2_reg;
            end else if (prod2_reg[64:16] > LIM) begin
                g_next   = GW'(LIM);
                oor_next = 1'b1;
            end
        end
        assign oor_ax[a] = oor_next;

        // Base cell and fraction; the nearest index is the rounded coordinate.
        assign c    = g3_reg[GW-1:16];
        assign nsum = {1'b0, g3_reg} + (GW+1)'(32768);

        always_comb begin
            f_next = {1'b0, g3_reg[15:0]};
            b_next = {1'b0, c};
            if (ctl3_reg.nearest) begin
                b_next = nsum[GW:16];
            end else if (c >= MXW'(DA - 1)) begin
                b_next = MCW'(DA - 2);
                f_next = 17'd65536;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[1]) diff1_reg <= diff_next;
            if (adv[2]) begin
                prod2_reg <= 65'(mag) * 65'(inv_reg[a]);
                neg2_reg  <= diff1_reg[32];
            end
            if (adv[3]) g3_reg <= g_next;
            if (adv[4]) begin
                b4_reg[a] <= b_next;
                f4_reg[a] <= f_next;
            end
        end
    end

    // Grid banks by index parity; writes and reads both happen at the memory stage.
    logic [SW-1:0] bank_rd_reg [8];
    logic [2:0]    par5_reg;
    logic [16:0]   f5_reg [3];

    for (genvar k = 0; k < 8; k++) begin : g_bank
        localparam bit PX = ((k % 2) == 1);
        localparam bit PY = (((k / 2) % 2) == 1);
        localparam bit PZ = (((k / 4) % 2) == 1);

        logic [SW-1:0]  mem [BANK_DEPTH];
        logic [MCW-1:0] cx, cy, cz;
        logic [BAW-1:0] raddr;
        logic [BAW-1:0] waddr;
        logic           we;

        assign cx = (b4_reg[0][0] == PX) ? b4_reg[0] : b4_reg[0] + 1'b1;
        assign cy = (b4_reg[1][0] == PY) ? b4_reg[1] : b4_reg[1] + 1'b1;
        assign cz = (b4_reg[2][0] == PZ) ? b4_reg[2] : b4_reg[2] + 1'b1;
        assign raddr = {cz[HZW:1], cy[HYW:1], cx[HXW:1]};
        assign waddr = {wr4_reg.z[HZW:1], wr4_reg.y[HYW:1], wr4_reg.x[HXW:1]};
        assign we = vld_reg[4] && adv[5] && ctl4_reg.wr && wr4_reg.ok &&
                    (wr4_reg.x[0] == PX) && (wr4_reg.y[0] == PY) && (wr4_reg.z[0] == PZ);

        always_ff @(posedge aclk) begin
            if (we) mem[waddr] <= wr4_reg.d;
            if (adv[5]) bank_rd_reg[k] <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            par5_reg <= {b4_reg[2][0], b4_reg[1][0], b4_reg[0][0]};
            for (int a = 0; a < 3; a++) begin
                f5_reg[a] <= f4_reg[a];
            end
        end
    end

    // Blend along x for the four corner pairs; the nearest sample is the base corner.
    logic signed [RW-1:0] r6_reg [4];
    logic signed [SW-1:0] nv6_reg;
    logic [16:0]          fy6_reg, fz6_reg;
    logic signed [17:0]   fx_s, omfx;

    assign fx_s = $signed({1'b0, f5_reg[0]});
    assign omfx = 18'sd65536 - fx_s;

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            for (int j = 0; j < 4; j++) begin
                r6_reg[j] <=
                    $signed(bank_rd_reg[{par5_reg[2] ^ j[1], par5_reg[1] ^ j[0], par5_reg[0]}])
                        * omfx +
                    $signed(bank_rd_reg[{par5_reg[2] ^ j[1], par5_reg[1] ^ j[0], ~par5_reg[0]}])
                        * fx_s;
            end
            nv6_reg <= $signed(bank_rd_reg[par5_reg]);
            fy6_reg <= f5_reg[1];
            fz6_reg <= f5_reg[2];
        end
    end

    // Blend along y and round half up to Q16.
    logic signed [PW-1:0]  p7_reg [2];
    logic signed [SW-1:0]  nv7_reg;
    logic [16:0]           fz7_reg;
    logic signed [17:0]    fy_s, omfy;
    logic signed [YSW-1:0] ys [2];

    assign fy_s = $signed({1'b0, fy6_reg});
    assign omfy = 18'sd65536 - fy_s;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            ys[j] = r6_reg[2*j] * omfy + r6_reg[2*j+1] * fy_s + YSW'(32768);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            for (int j = 0; j < 2; j++) begin
                p7_reg[j] <= PW'(ys[j] >>> 16);
            end
            nv7_reg <= nv6_reg;
            fz7_reg <= fz6_reg;
        end
    end

    // Blend along z, round half up to an integer and saturate.
    logic signed [17:0]    fz_s, omfz;
    logic signed [ZSW-1:0] zs, zr, sel;
    logic [15:0]           res_next;
    logic [15:0]           res_reg;
    logic                  oor_reg;
    logic                  kind_reg;

    assign fz_s = $signed({1'b0, fz7_reg});
    assign omfz = 18'sd65536 - fz_s;
    assign zs   = p7_reg[0] * omfz + p7_reg[1] * fz_s + (ZSW'(1) <<< 31);
    assign zr   = zs >>> 32;

    always_comb begin
        sel = ctl7_reg.nearest ? ZSW'(nv7_reg) : zr;
        if (sel > ZSW'(32767)) begin
            res_next = 16'h7FFF;
        end else if (sel < -ZSW'(32768)) begin
            res_next = 16'h8000;
        end else begin
            res_next = sel[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[8]) begin
            res_reg  <= res_next;
            oor_reg  <= ctl7_reg.oor;
            kind_reg <= ctl7_reg.nearest ? KIND_NEAREST : KIND_TRILIN;
        end
    end

    assign m_tvalid = vld_reg[8];
    assign m_tdata  = {7'b0, oor_reg, res_reg};
    assign m_tuser  = kind_reg;

endmodule
`default_nettype wire

// ----- sv/tgi_checker.sv -----
// Port-level checker of the grid interpolator and its bind to the top level.
`default_nettype none
module tgi_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With the output register free, nothing upstream can hold the input back.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // A result being taken lets every stage move.
    a_ready_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |-> s_tready)
        else $error("input stalled while a result is taken");

endmodule

bind trilinear_grid_interpolator_top tgi_checker u_tgi_checker (.*);
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the trilinear grid interpolator top level.
`default_nettype none
module testbench;
    import tgi_pkg::*;

    localparam int  GRID_CELLS  = 32 * 32 * 32;
    localparam int  TAIL_CYCLES = 24;
    localparam int  HOLD_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 3000000;

    // One input beat of the block.
    typedef struct packed {
        logic [1:0]  req;
        logic [4:0]  cx;
        logic [4:0]  cy;
        logic [4:0]  cz;
        logic [15:0] sample;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } grid_beat_t;

    // One query result.
    typedef struct packed {
        logic [15:0] value;
        logic        oor;
        logic        kind;
    } query_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wen;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    trilinear_grid_interpolator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Register shadow, sample store as the block sees it, and the stimulus-side write map.
    logic [31:0]   cfg_shadow [6];
    logic [15:0]   grid_model [GRID_CELLS];
    bit            gen_written [GRID_CELLS];
    grid_beat_t    pending_beats [$];
    query_result_t expected_results [$];
    grid_beat_t    cur_beat;
    int            mismatches;
    int            idle_max;
    int            tx_gap;
    int            rx_stall;
    int            hold_left;
    int            hold_trig;
    int            hold_seen;
    longint        cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Grid coordinate of one axis in Q16.16 after clamping.
    function automatic longint unsigned axis_coord(logic [31:0] p, logic [31:0] o,
                                                   logic [31:0] inv, inout bit oor);
        longint s;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned g;
        s = longint'($signed(p)) - longint'($signed(o));
        mag = (s < 0) ? longint'(-s) : longint'(s);
        prod = mag * {32'd0, inv};
        if (s < 0) begin
            if (prod != 0) oor = 1'b1;
            return 0;
        end
        g = prod >> 16;
        if (g > (longint'(31) << 16)) begin
            oor = 1'b1;
            g = longint'(31) << 16;
        end
        return g;
    endfunction

    // Cell index and fraction for the blend; the upper edge uses the last cell at 1.0.
    function automatic void cell_split(longint unsigned g, output int i, output longint f);
        if ((g >> 16) >= 31) begin
            i = 30;
            f = 65536;
        end else begin
            i = int'(g >> 16);
            f = longint'(g & 64'hFFFF);
        end
    endfunction

    function automatic int cell_addr(int x, int y, int z);
        return (z * 32 + y) * 32 + x;
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        return a * (65536 - f) + b * f;
    endfunction

    function automatic longint sample_at(int x, int y, int z);
        return longint'($signed(grid_model[cell_addr(x, y, z)]));
    endfunction

    // Expected result of a query against the current grid and registers.
    function automatic query_result_t predict_query(grid_beat_t b);
        query_result_t r;
        bit oor;
        longint unsigned gx, gy, gz;
        int ix, iy, iz;
        longint fx, fy, fz, r0, r1, v;
        longint plane [2];
        oor = 1'b0;
        gx = axis_coord(b.px, cfg_shadow[CFG_ORIGIN_X], cfg_shadow[CFG_INV_STEP_X], oor);
        gy = axis_coord(b.py, cfg_shadow[CFG_ORIGIN_Y], cfg_shadow[CFG_INV_STEP_Y], oor);
        gz = axis_coord(b.pz, cfg_shadow[CFG_ORIGIN_Z], cfg_shadow[CFG_INV_STEP_Z], oor);
        if (b.req == REQ_TRILIN) begin
            cell_split(gx, ix, fx);
            cell_split(gy, iy, fy);
            cell_split(gz, iz, fz);
            for (int k = 0; k < 2; k++) begin
                r0 = blend(sample_at(ix, iy, iz + k), sample_at(ix + 1, iy, iz + k), fx);
                r1 = blend(sample_at(ix, iy + 1, iz + k), sample_at(ix + 1, iy + 1, iz + k), fx);
                plane[k] = (blend(r0, r1, fy) + (longint'(1) << 15)) >>> 16;
            end
            v = (blend(plane[0], plane[1], fz) + (longint'(1) << 31)) >>> 32;
            r.kind = KIND_TRILIN;
        end else begin
            v = sample_at(int'((gx + 16'h8000) >> 16), int'((gy + 16'h8000) >> 16),
                          int'((gz + 16'h8000) >> 16));
            r.kind = KIND_NEAREST;
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.value = v[15:0];
        r.oor = oor;
        return r;
    endfunction

    // Queue a sample write and note the cell as written.
    task automatic push_write(int x, int y, int z, logic [15:0] val);
        grid_beat_t b;
        b = '{REQ_WRITE, x[4:0], y[4:0], z[4:0], val, $urandom, $urandom, $urandom};
        gen_written[cell_addr(x, y, z)] = 1'b1;
        pending_beats.push_back(b);
    endtask

    // Queue a query, first writing any cell it would read that holds no sample yet.
    task automatic push_query(logic [1:0] req, logic [31:0] px, logic [31:0] py,
                              logic [31:0] pz);
        grid_beat_t b;
        bit oor;
        longint unsigned gx, gy, gz;
        int ix, iy, iz, x, y, z;
        longint f;
        b = '{req, 5'($urandom), 5'($urandom), 5'($urandom), 16'($urandom), px, py, pz};
        oor = 1'b0;
        gx = axis_coord(px, cfg_shadow[CFG_ORIGIN_X], cfg_shadow[CFG_INV_STEP_X], oor);
        gy = axis_coord(py, cfg_shadow[CFG_ORIGIN_Y], cfg_shadow[CFG_INV_STEP_Y], oor);
        gz = axis_coord(pz, cfg_shadow[CFG_ORIGIN_Z], cfg_shadow[CFG_INV_STEP_Z], oor);
        if (req == REQ_TRILIN) begin
            cell_split(gx, ix, f);
            cell_split(gy, iy, f);
            cell_split(gz, iz, f);
            for (int c = 0; c < 8; c++) begin
                x = ix + c % 2;
                y = iy + (c / 2) % 2;
                z = iz + c / 4;
                if (!gen_written[cell_addr(x, y, z)]) push_write(x, y, z, 16'($urandom));
            end
        end else if (req == REQ_NEAREST) begin
            x = int'((gx + 16'h8000) >> 16);
            y = int'((gy + 16'h8000) >> 16);
            z = int'((gz + 16'h8000) >> 16);
            if (!gen_written[cell_addr(x, y, z)]) push_write(x, y, z, 16'($urandom));
        end
        pending_beats.push_back(b);
    endtask

    // Point on one axis: mostly near the grid in cell units, sometimes anywhere.
    function automatic logic [31:0] pick_coord(logic [31:0] o, logic [31:0] inv);
        longint t;
        if (inv == 0 || $urandom_range(0, 9) == 0) return $urandom;
        t = longint'($urandom_range(0, 36 << 16)) - (longint'(2) << 16);
        t = (t * 65536) / longint'({32'd0, inv});
        return o + t[31:0];
    endfunction

    // Write all registers while the block is idle.
    task automatic write_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        logic [31:0] vals [6];
        vals = '{ox, oy, oz, sx, sy, sz};
        for (int i = 0; i < 6; i++) begin
            @(posedge aclk);
            cfg_wen   <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= vals[i];
            cfg_shadow[i] = vals[i];
        end
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Wait until every queued beat is taken and every result has come back.
    task automatic drain();
        while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Queue about n beats in total, the writes that queries need included.
    task automatic random_phase(int n);
        int r;
        int start;
        logic [1:0] req;
        start = pending_beats.size();
        while (pending_beats.size() - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                push_write($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                           16'($urandom));
            end else if (r < 19) begin
                pending_beats.push_back('{2'd3, 5'($urandom), 5'($urandom), 5'($urandom),
                                          16'($urandom), $urandom, $urandom, $urandom});
            end else begin
                req = (r < 62) ? REQ_TRILIN : REQ_NEAREST;
                push_query(req,
                           pick_coord(cfg_shadow[CFG_ORIGIN_X], cfg_shadow[CFG_INV_STEP_X]),
                           pick_coord(cfg_shadow[CFG_ORIGIN_Y], cfg_shadow[CFG_INV_STEP_Y]),
                           pick_coord(cfg_shadow[CFG_ORIGIN_Z], cfg_shadow[CFG_INV_STEP_Z]));
            end
        end
    endtask

    // Driver: offers the next pending beat after a random gap and predicts on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                if (cur_beat.req == REQ_WRITE) begin
                    grid_model[cell_addr(cur_beat.cx, cur_beat.cy, cur_beat.cz)] =
                        cur_beat.sample;
                end else if (cur_beat.req == REQ_TRILIN || cur_beat.req == REQ_NEAREST) begin
                    expected_results.push_back(predict_query(cur_beat));
                end
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                cur_beat = pending_beats.pop_front();
                s_tdata  <= {1'b0, cur_beat.pz, cur_beat.py, cur_beat.px, cur_beat.sample,
                             cur_beat.cz, cur_beat.cy, cur_beat.cx};
                s_tuser  <= cur_beat.req;
                s_tvalid <= 1'b1;
                tx_gap = $urandom_range(0, idle_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long result-side hold-off, started by the stimulus through a trigger count.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge aclk) begin
        query_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[15:0], m_tdata[16], m_tuser[0]};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: value=%0d oor=%0b kind=%0b",
                                 $signed(got.value), got.oor, got.kind);
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected value=%0d oor=%0b kind=%0b, got value=%0d oor=%0b kind=%0b",
                                     $signed(want.value), want.oor, want.kind,
                                     $signed(got.value), got.oor, got.kind);
                    end
                end
                rx_stall = $urandom_range(0, idle_max);
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Stimulus: reset, directed beats, then random phases under several register settings.
    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_wen    = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        mismatches = 0;
        cycles     = 0;
        hold_trig  = 0;
        idle_max   = 13;
        cfg_shadow = '{32'd0, 32'd0, 32'd0, ONE_Q16, ONE_Q16, ONE_Q16};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: sample extremes, exact cells, half points, upper edge and clamps.
        push_write(0, 0, 0, 16'h8000);
        push_write(1, 0, 0, 16'h7FFF);
        push_write(31, 31, 31, 16'h7FFF);
        push_write(30, 31, 31, 16'h8000);
        push_query(REQ_TRILIN, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_query(REQ_TRILIN, 32'h0000_8000, 32'h0000_0000, 32'h0000_0000);
        push_query(REQ_NEAREST, 32'h0000_8000, 32'h0000_0000, 32'h0000_0000);
        push_query(REQ_NEAREST, 32'h0000_7FFF, 32'h0000_0000, 32'h0000_0000);
        push_query(REQ_TRILIN, 32'h001F_0000, 32'h001F_0000, 32'h001F_0000);
        push_query(REQ_NEAREST, 32'h001E_8000, 32'h001F_0000, 32'h001F_0000);
        push_query(REQ_TRILIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_query(REQ_NEAREST, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_query(REQ_TRILIN, 32'hFFFF_FFFF, 32'h0001_4000, 32'h0002_C000);
        push_query(REQ_TRILIN, 32'h000A_1234, 32'h0011_FFFF, 32'h001E_FFFF);
        push_query(REQ_NEAREST, 32'h0020_0000, 32'h0000_0000, 32'h0010_0000);
        pending_beats.push_back('{2'd3, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1, '1, '1});
        drain();

        // Default registers, with the long hold-off while the sender keeps offering.
        idle_max = 3;
        @(posedge aclk);
        hold_trig <= hold_trig + 1;
        random_phase(300);
        drain();

        idle_max = 13;
        write_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
        random_phase(120);
        drain();

        idle_max = 0;
        write_config(32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_0001,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(150);
        drain();

        idle_max = 13;
        write_config(32'hFFF0_0000, 32'h0004_8000, 32'h1234_5678,
                     32'h0000_8000, 32'h0002_0000, 32'h0001_0000);
        random_phase(400);
        drain();

        write_config($urandom, $urandom, $urandom, 32'h0001_0000 + $urandom_range(0, 65535),
                     32'h0000_4000 + $urandom_range(0, 65535), 32'h0001_8000);
        random_phase(400);
        drain();

        idle_max = 6;
        write_config($urandom, $urandom, $urandom, 32'h0000_C000, 32'h0003_0000, ONE_Q16);
        random_phase(360);
        drain();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
